### sv/mqlb_pkg.sv
// shared types and constants for the multi-queue linked buffer
// no dependencies; used by mqlb_store, mqlb_qtab and the top level
`timescale 1ns / 1ps

package mqlb_pkg;

    typedef enum logic {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    localparam logic signed [31:0] UNDERFLOW_VALUE = -32'sd404;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOOK = 3'b010,
        S_WB   = 3'b100
    } t_state;

    // entry store strobes
    typedef struct packed {
        logic rd_en;
        logic link_we;
        logic val_we;
        logic alloc;
    } t_store_ctl;

    // queue table strobes
    typedef struct packed {
        logic rd_en;
        logic head_we;
        logic tail_we;
        logic set_ne;
        logic clr_ne;
    } t_qtab_ctl;

endpackage

### sv/mqlb_store.sv
// entry store: link memory, value memory and the untouched-region fill count
// depends on mqlb_pkg
`timescale 1ns / 1ps

module mqlb_store #(
    parameter int ENTRIES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mqlb_pkg::t_store_ctl          i_ctl,
    input  logic [$clog2(ENTRIES)-1:0]    i_rd_addr,
    input  logic [$clog2(ENTRIES)-1:0]    i_lk_addr,
    input  logic [$clog2(ENTRIES+1)-1:0]  i_lk_data,
    input  logic [$clog2(ENTRIES)-1:0]    i_val_addr,
    input  logic [31:0]                   i_val_data,
    output logic [$clog2(ENTRIES+1)-1:0]  o_link,
    output logic [31:0]                   o_value
);

    localparam int AW = $clog2(ENTRIES);
    localparam int PW = $clog2(ENTRIES+1);

    logic [PW-1:0] r_link_mem [ENTRIES];
    logic [31:0]   r_val_mem  [ENTRIES];
    logic [PW-1:0] r_link_rd;
    logic [31:0]   r_val_rd;
    logic [AW-1:0] r_rd_addr;
    logic          r_rd_fresh;
    logic [PW-1:0] r_fill;
    logic [PW-1:0] n_fill;

    always_ff @(posedge i_clk) begin
        if (i_ctl.link_we) begin
            r_link_mem[i_lk_addr] <= i_lk_data;
        end
        if (i_ctl.val_we) begin
            r_val_mem[i_val_addr] <= i_val_data;
        end
        if (i_ctl.rd_en) begin
            r_link_rd <= r_link_mem[i_rd_addr];
            r_val_rd  <= r_val_mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    // entries at or above the fill count were never written: they still chain to the next
    always_comb begin
        n_fill = r_fill;
        if (i_ctl.alloc && (PW'(i_val_addr) == r_fill)) begin
            n_fill = r_fill + PW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_rd_fresh <= 1'b0;
        end else begin
            r_fill <= n_fill;
            if (i_ctl.rd_en) begin
                r_rd_fresh <= (PW'(i_rd_addr) >= r_fill);
            end
        end
    end

    assign o_link  = r_rd_fresh ? (PW'(r_rd_addr) + PW'(1)) : r_link_rd;
    assign o_value = r_val_rd;

endmodule

### sv/mqlb_qtab.sv
// queue table: head and tail memories plus one nonempty flag per queue
// depends on mqlb_pkg
`timescale 1ns / 1ps

module mqlb_qtab #(
    parameter int ENTRIES = 16,
    parameter int QUEUES  = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mqlb_pkg::t_qtab_ctl                  i_ctl,
    input  logic [(QUEUES>1 ? $clog2(QUEUES) : 1)-1:0] i_rd_addr,
    input  logic [(QUEUES>1 ? $clog2(QUEUES) : 1)-1:0] i_wr_addr,
    input  logic [$clog2(ENTRIES)-1:0]           i_head_data,
    input  logic [$clog2(ENTRIES)-1:0]           i_tail_data,
    output logic [$clog2(ENTRIES)-1:0]           o_head,
    output logic [$clog2(ENTRIES)-1:0]           o_tail,
    output logic                                 o_nonempty
);

    localparam int AW = $clog2(ENTRIES);

    logic [AW-1:0]     r_head_mem [QUEUES];
    logic [AW-1:0]     r_tail_mem [QUEUES];
    logic [QUEUES-1:0] r_ne;
    logic [AW-1:0]     r_head_rd;
    logic [AW-1:0]     r_tail_rd;
    logic              r_ne_rd;

    always_ff @(posedge i_clk) begin
        if (i_ctl.head_we) begin
            r_head_mem[i_wr_addr] <= i_head_data;
        end
        if (i_ctl.tail_we) begin
            r_tail_mem[i_wr_addr] <= i_tail_data;
        end
        if (i_ctl.rd_en) begin
            r_head_rd <= r_head_mem[i_rd_addr];
            r_tail_rd <= r_tail_mem[i_rd_addr];
            r_ne_rd   <= r_ne[i_rd_addr];
        end
    end

    // a queue with its flag clear is empty; its stale tail is ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ne <= '0;
        end else begin
            if (i_ctl.set_ne) begin
                r_ne[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.clr_ne) begin
                r_ne[i_wr_addr] <= 1'b0;
            end
        end
    end

    assign o_head     = r_head_rd;
    assign o_tail     = r_tail_rd;
    assign o_nonempty = r_ne_rd;

endmodule

### sv/multi_queue_linked_buffer_core.sv
// top level: request sequencer, free-list head and result register
// depends on mqlb_pkg, mqlb_store and mqlb_qtab
`timescale 1ns / 1ps

// Several FIFO queues share one store of ENTRIES linked entries.
// Input channel (s_axis): one request per transfer, enqueue or dequeue on
// queue 1..QUEUES. Output channel (m_axis): exactly one result per request,
// status plus the dequeued value (-404 on underflow, 0 for enqueues).
// Each request walks three steps: accept (queue table read), lookup (entry
// store read at the free head or the queue head), writeback (link, pointer
// and value updates, result loaded). A new request is not taken until the
// last one has left writeback; the sequencer waits on the registered reads
// of the queue table and then the entry store, which have a single read
// port each.
// o_s_axis_tready is high only while the sequencer is idle.
// If the receiver stalls with a result still held, writeback waits and the
// input stays blocked until the result register can take the new result.
// Reset empties every queue and chains all entries into the free list in
// index order; it takes effect at once, with no clearing pass.

module multi_queue_linked_buffer_core #(
    parameter int ENTRIES = 16,
    parameter int QUEUES  = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // cmd, queue_number[2:0], push_value[31:0], zero pad
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata    // status[1:0], pop_value[31:0], zero pad
);

    localparam int AW = $clog2(ENTRIES);
    localparam int PW = $clog2(ENTRIES+1);
    localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;

    mqlb_pkg::t_state     r_state, n_state;
    logic                 r_cmd;
    logic [QW-1:0]        r_qidx;
    logic                 r_valid_q;
    logic [31:0]          r_val;
    logic [PW-1:0]        r_free_head, n_free_head;
    logic                 r_out_valid;
    logic [1:0]           r_out_status;
    logic [31:0]          r_out_pop;

    logic                 w_accept;
    logic [2:0]           w_qn;
    logic [QW-1:0]        w_in_qidx;
    logic                 w_in_valid_q;
    logic                 w_enq;
    logic [AW-1:0]        w_idx;
    logic                 w_err;
    logic                 w_last;
    logic                 w_fire;
    logic                 w_ok;
    logic [1:0]           w_status;
    logic [31:0]          w_pop;

    mqlb_pkg::t_store_ctl w_sctl;
    mqlb_pkg::t_qtab_ctl  w_qctl;
    logic [AW-1:0]        w_lk_addr;
    logic [PW-1:0]        w_lk_data;
    logic [AW-1:0]        w_head_data;
    logic [PW-1:0]        s_link;
    logic [31:0]          s_value;
    logic [AW-1:0]        q_head;
    logic [AW-1:0]        q_tail;
    logic                 q_ne;

    assign o_s_axis_tready = (r_state == mqlb_pkg::S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_qn            = i_s_axis_tdata[3:1];
    assign w_in_valid_q    = (w_qn != 3'd0) && (32'(w_qn) <= QUEUES);
    assign w_in_qidx       = QW'(32'(w_qn) - 32'd1);

    assign w_enq   = (r_cmd == mqlb_pkg::CMD_ENQ);
    assign w_idx   = w_enq ? r_free_head[AW-1:0] : q_head;
    assign w_last  = (q_head == q_tail);
    assign w_err   = !r_valid_q || (w_enq ? (r_free_head == PW'(ENTRIES)) : !q_ne);
    assign w_fire  = (r_state == mqlb_pkg::S_WB) && (!r_out_valid || i_m_axis_tready);
    assign w_ok    = w_fire && !w_err;

    always_comb begin
        w_sctl.rd_en   = (r_state == mqlb_pkg::S_LOOK);
        w_sctl.link_we = w_ok && (w_enq ? q_ne : 1'b1);
        w_sctl.val_we  = w_ok && w_enq;
        w_sctl.alloc   = w_ok && w_enq;
        w_lk_addr      = w_enq ? q_tail : w_idx;
        w_lk_data      = w_enq ? PW'(w_idx) : r_free_head;

        w_qctl.rd_en   = w_accept;
        w_qctl.head_we = w_ok && (w_enq ? !q_ne : !w_last);
        w_qctl.tail_we = w_ok && w_enq;
        w_qctl.set_ne  = w_ok && w_enq;
        w_qctl.clr_ne  = w_ok && !w_enq && w_last;
        w_head_data    = w_enq ? w_idx : s_link[AW-1:0];
    end

    always_comb begin
        if (!w_err) begin
            w_status = mqlb_pkg::ST_OK;
            w_pop    = w_enq ? 32'd0 : s_value;
        end else if (w_enq) begin
            w_status = mqlb_pkg::ST_OVERFLOW;
            w_pop    = 32'd0;
        end else begin
            w_status = mqlb_pkg::ST_UNDERFLOW;
            w_pop    = mqlb_pkg::UNDERFLOW_VALUE;
        end
    end

    always_comb begin
        n_free_head = r_free_head;
        if (w_ok) begin
            n_free_head = w_enq ? s_link : PW'(w_idx);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mqlb_pkg::S_IDLE: begin
                if (w_accept) n_state = mqlb_pkg::S_LOOK;
            end
            mqlb_pkg::S_LOOK: begin
                n_state = mqlb_pkg::S_WB;
            end
            mqlb_pkg::S_WB: begin
                if (w_fire) n_state = mqlb_pkg::S_IDLE;
            end
            default: begin
                n_state = mqlb_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mqlb_pkg::S_IDLE;
            r_free_head <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free_head <= n_free_head;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd     <= i_s_axis_tdata[0];
            r_qidx    <= w_in_qidx;
            r_valid_q <= w_in_valid_q;
            r_val     <= i_s_axis_tdata[35:4];
        end
        if (w_fire) begin
            r_out_status <= w_status;
            r_out_pop    <= w_pop;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out_pop, r_out_status};

    mqlb_qtab #(
        .ENTRIES (ENTRIES),
        .QUEUES  (QUEUES)
    ) u_qtab (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_qctl),
        .i_rd_addr   (w_in_qidx),
        .i_wr_addr   (r_qidx),
        .i_head_data (w_head_data),
        .i_tail_data (w_idx),
        .o_head      (q_head),
        .o_tail      (q_tail),
        .o_nonempty  (q_ne)
    );

    mqlb_store #(
        .ENTRIES (ENTRIES)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_sctl),
        .i_rd_addr  (w_idx),
        .i_lk_addr  (w_lk_addr),
        .i_lk_data  (w_lk_data),
        .i_val_addr (w_idx),
        .i_val_data (r_val),
        .o_link     (s_link),
        .o_value    (s_value)
    );

`ifndef SYNTHESIS
    a_free_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_head <= PW'(ENTRIES))
        else $error("free head beyond null code");

    a_accept_to_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == mqlb_pkg::S_LOOK) && !o_s_axis_tready)
        else $error("request accepted without lookup");

    a_result_from_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == mqlb_pkg::S_WB))
        else $error("result raised outside writeback");

    a_fire_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> (r_state == mqlb_pkg::S_IDLE) && r_out_valid)
        else $error("writeback did not complete");
`endif

endmodule
